[hdl/brs_pkg.sv]
// ----------------------------------------------------------------------------
// brs_pkg: shared types and constants for the block request splitter
// Opcodes, result codes, queue descriptor, geometry and a helper function.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int SPP_LOG2       = 3;   // 8 sectors per 4 KiB page
  localparam int SPP_M1         = (1 << SPP_LOG2) - 1;
  localparam int MAX_PIECES     = 64;
  localparam int PIECE_CNT_W    = 7;   // holds 1..MAX_PIECES
  localparam int MAX_SLOTS_LOG2 = 5;   // 32 page slots per piece at most

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAGES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNITS = 2'd1;

  localparam int QUEUE_DEPTH = 2;      // power of two, pointers wrap naturally
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = QPTR_W + 1;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_TRIM    = 2'd2,
    OP_INVALID = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_MANY = 2'd1,
    ST_BAD_OP   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PK_READ     = 2'd0,
    PK_WRITE    = 2'd1,
    PK_RMW_READ = 2'd2,
    PK_TRIM     = 2'd3
  } piece_kind_t;

  typedef enum logic [2:0] {
    MD_READ,
    MD_WRITE,
    MD_TRIM,
    MD_ERR_PIECES,
    MD_ERR_OP
  } mode_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  // effective geometry after limiting
  typedef struct packed {
    logic [2:0] lp;   // log2 pages per mapping unit
    logic [2:0] lm;   // log2 mapping units per I/O unit
  } geom_t;

  // classified request, front to back
  typedef struct packed {
    mode_t                  mode;
    geom_t                  geom;
    logic [PIECE_CNT_W-1:0] n_pieces;
    logic [28:0]            pg_first;
    logic [29:0]            pg_end;
    logic [31:0]            unit;      // first unit (trim: first fully covered)
    logic [15:0]            trim_len;
  } desc_t;

  typedef struct packed {
    status_t     status;
    piece_kind_t kind;
    logic [31:0] first_lpa;
    logic [15:0] unit_count;
    logic [4:0]  page_offset;
    logic [31:0] page_mask;
    logic [10:0] first_buffer_index;
    logic        last_piece;
  } piece_t;

  // low k bits set, k in 0..32
  function automatic logic [31:0] thermo(input logic [5:0] k);
    logic [32:0] t;
    t = (33'd1 << k) - 33'd1;
    return t[31:0];
  endfunction

endpackage

[hdl/brs_in_if.sv]
// ----------------------------------------------------------------------------
// brs_in_if: host request channel
// Valid/ready channel carrying one block request per item.
// ----------------------------------------------------------------------------
interface brs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] offset_sectors;
  logic [15:0] size_sectors;

  modport source (output valid, opcode, offset_sectors, size_sectors, input ready);
  modport sink   (input valid, opcode, offset_sectors, size_sectors, output ready);
endinterface

[hdl/brs_out_if.sv]
// ----------------------------------------------------------------------------
// brs_out_if: piece result channel
// Valid/ready channel carrying one translation piece per item.
// ----------------------------------------------------------------------------
interface brs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  piece_kind;
  logic [31:0] first_lpa;
  logic [15:0] unit_count;
  logic [4:0]  page_offset;
  logic [31:0] page_mask;
  logic [10:0] first_buffer_index;
  logic        last_piece;

  modport source (output valid, status, piece_kind, first_lpa, unit_count, page_offset,
                  page_mask, first_buffer_index, last_piece, input ready);
  modport sink   (input valid, status, piece_kind, first_lpa, unit_count, page_offset,
                  page_mask, first_buffer_index, last_piece, output ready);
endinterface

[hdl/brs_cfg_if.sv]
// ----------------------------------------------------------------------------
// brs_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface brs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [2:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/brs_front.sv]
// ----------------------------------------------------------------------------
// brs_front: request intake and classification
// Registers one request, computes page/unit bounds and piece count, and
// pushes a descriptor into the queue.
// ----------------------------------------------------------------------------
module brs_front (
  input  logic          clk,
  input  logic          rst_n,
  brs_in_if.sink        in_ch,
  input  brs_pkg::geom_t geom,
  input  logic          q_full,
  output logic          q_push,
  output brs_pkg::desc_t q_data
);
  import brs_pkg::*;

  logic        vld_r, vld_nxt;
  opcode_t     op_r;
  logic [31:0] off_r;
  logic [15:0] size_r;
  geom_t       geom_r;

  logic        drop, free_slot, accept;
  logic [3:0]  sh;
  logic [9:0]  mus;
  logic [8:0]  mus_m1;
  logic [32:0] end_s;
  logic [32:0] s_unit, e_unit;
  logic [28:0] pg_first;
  logic [29:0] pg_end;
  logic [29:0] n_rd;
  logic [31:0] s_mu, e_mu, du;
  logic [5:0]  io_m1;
  logic [32:0] n_wr;

  // zero-length read or write produces nothing
  assign drop = vld_r && (size_r == 16'd0) && ((op_r == OP_READ) || (op_r == OP_WRITE));
  assign free_slot = !vld_r || drop || !q_full;
  assign accept = in_ch.valid && free_slot;
  assign in_ch.ready = free_slot;
  assign q_push = vld_r && !drop && !q_full;
  assign vld_nxt = free_slot ? accept : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= opcode_t'(in_ch.opcode);
      off_r  <= in_ch.offset_sectors;
      size_r <= in_ch.size_sectors;
      geom_r <= geom;
    end
  end

  always_comb begin
    sh       = 4'(SPP_LOG2) + {1'b0, geom_r.lp};
    mus      = 10'd1 << sh;
    mus_m1   = 9'(mus - 10'd1);
    end_s    = {1'b0, off_r} + {17'b0, size_r};
    // trim: round start up and end down to unit boundaries
    s_unit   = ({1'b0, off_r} + {24'b0, mus_m1}) >> sh;
    e_unit   = end_s >> sh;
    // read: touched page range
    pg_first = 29'(off_r >> SPP_LOG2);
    pg_end   = 30'((end_s + 33'(SPP_M1)) >> SPP_LOG2);
    n_rd     = pg_end - {1'b0, pg_first};
    // write: widened unit range, cut into I/O units
    s_mu     = off_r >> sh;
    e_mu     = 32'((end_s + {24'b0, mus_m1}) >> sh);
    du       = e_mu - s_mu;
    io_m1    = 6'((7'd1 << geom_r.lm) - 7'd1);
    n_wr     = ({1'b0, du} + {27'b0, io_m1}) >> geom_r.lm;
  end

  always_comb begin
    q_data          = '0;
    q_data.geom     = geom_r;
    q_data.pg_first = pg_first;
    q_data.pg_end   = pg_end;
    q_data.n_pieces = PIECE_CNT_W'(1);
    unique case (op_r)
      OP_READ: begin
        if (n_rd > 30'(MAX_PIECES)) begin
          q_data.mode = MD_ERR_PIECES;
        end else begin
          q_data.mode     = MD_READ;
          q_data.n_pieces = PIECE_CNT_W'(n_rd);
        end
      end
      OP_WRITE: begin
        q_data.unit = s_mu;
        if (n_wr > 33'(MAX_PIECES)) begin
          q_data.mode = MD_ERR_PIECES;
        end else begin
          q_data.mode     = MD_WRITE;
          q_data.n_pieces = PIECE_CNT_W'(n_wr);
        end
      end
      OP_TRIM: begin
        q_data.mode     = MD_TRIM;
        q_data.unit     = 32'(s_unit);
        q_data.trim_len = (e_unit > s_unit) ? 16'(e_unit - s_unit) : 16'd0;
      end
      default: begin
        q_data.mode = MD_ERR_OP;
      end
    endcase
  end

endmodule

[hdl/brs_queue.sv]
// ----------------------------------------------------------------------------
// brs_queue: descriptor queue between front and back
// Small register FIFO; push when not full, pop when not empty.
// ----------------------------------------------------------------------------
module brs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  brs_pkg::desc_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output brs_pkg::desc_t pop_data
);
  import brs_pkg::*;

  desc_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hdl/brs_back.sv]
// ----------------------------------------------------------------------------
// brs_back: piece generator
// Walks a descriptor into the output register, one piece per unstalled cycle.
// ----------------------------------------------------------------------------
module brs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  brs_pkg::desc_t q_data,
  output logic           q_pop,
  brs_out_if.source      out_ch
);
  import brs_pkg::*;

  back_state_t            state_r, state_nxt;
  desc_t                  desc_r;
  logic [PIECE_CNT_W-1:0] idx_r;
  logic [30:0]            cur_r;     // page (read) or unit base page (write)
  logic [31:0]            unit_r;
  logic                   out_vld_r;
  piece_t                 piece_r, piece;

  logic        emit, last;
  logic [2:0]  slog;
  logic [5:0]  slots;
  logic [30:0] pgs, pge, lo_full, hi_full;
  logic [5:0]  lo, hi;
  logic [31:0] wr_mask;
  logic        hole;
  logic [4:0]  ofs_mask, rd_ofs;
  logic [15:0] io_units;

  assign last = (idx_r == desc_r.n_pieces - PIECE_CNT_W'(1));

  always_comb begin
    slog     = desc_r.geom.lp + desc_r.geom.lm;
    slots    = 6'd1 << slog;
    io_units = 16'd1 << desc_r.geom.lm;
    pgs      = {2'b0, desc_r.pg_first};
    pge      = {1'b0, desc_r.pg_end};
    lo_full  = (pgs > cur_r) ? pgs - cur_r : '0;
    hi_full  = (pge > cur_r) ? pge - cur_r : '0;
    lo       = (lo_full > {25'b0, slots}) ? slots : lo_full[5:0];
    hi       = (hi_full > {25'b0, slots}) ? slots : hi_full[5:0];
    wr_mask  = thermo(hi) & ~thermo(lo);
    hole     = (wr_mask != thermo(slots));
    ofs_mask = 5'((6'd1 << desc_r.geom.lp) - 6'd1);
    rd_ofs   = cur_r[4:0] & ofs_mask;
  end

  always_comb begin
    piece            = '0;
    piece.last_piece = last;
    unique case (desc_r.mode)
      MD_READ: begin
        piece.kind               = PK_READ;
        piece.first_lpa          = 32'(cur_r >> desc_r.geom.lp);
        piece.unit_count         = 16'd1;
        piece.page_offset        = rd_ofs;
        piece.page_mask          = 32'd1 << rd_ofs;
        piece.first_buffer_index = 11'(idx_r);
      end
      MD_WRITE: begin
        piece.kind               = hole ? PK_RMW_READ : PK_WRITE;
        piece.first_lpa          = unit_r;
        piece.unit_count         = io_units;
        piece.page_mask          = wr_mask;
        piece.first_buffer_index = (cur_r > pgs) ? 11'(cur_r - pgs) : 11'd0;
      end
      MD_TRIM: begin
        piece.kind       = PK_TRIM;
        piece.first_lpa  = desc_r.unit;
        piece.unit_count = desc_r.trim_len;
      end
      MD_ERR_PIECES: begin
        piece.status = ST_TOO_MANY;
      end
      MD_ERR_OP: begin
        piece.status = ST_BAD_OP;
      end
      default: begin
        piece.status = ST_BAD_OP;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (!out_vld_r || out_ch.ready) begin
          emit = 1'b1;
          if (last) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_data;
      idx_r  <= '0;
      unit_r <= q_data.unit;
      if (q_data.mode == MD_WRITE) begin
        cur_r <= 31'(q_data.unit << q_data.geom.lp);
      end else begin
        cur_r <= {2'b0, q_data.pg_first};
      end
    end else if (emit) begin
      idx_r  <= idx_r + PIECE_CNT_W'(1);
      unit_r <= unit_r + {16'b0, io_units};
      if (desc_r.mode == MD_WRITE) begin
        cur_r <= cur_r + {25'b0, slots};
      end else begin
        cur_r <= cur_r + 31'd1;
      end
    end
    if (emit) begin
      piece_r <= piece;
    end
  end

  assign out_ch.valid              = out_vld_r;
  assign out_ch.status             = piece_r.status;
  assign out_ch.piece_kind         = piece_r.kind;
  assign out_ch.first_lpa          = piece_r.first_lpa;
  assign out_ch.unit_count         = piece_r.unit_count;
  assign out_ch.page_offset        = piece_r.page_offset;
  assign out_ch.page_mask          = piece_r.page_mask;
  assign out_ch.first_buffer_index = piece_r.first_buffer_index;
  assign out_ch.last_piece         = piece_r.last_piece;

endmodule

[hdl/block_request_splitter_top.sv]
// ----------------------------------------------------------------------------
// block_request_splitter_top: host block request to flash piece splitter
// Path: intake register, queue, piece generator load, output register.
// Throughput: one piece per cycle while the output is not stalled; a request
//   holds the piece generator until its last piece is emitted. Zero-length
//   reads and writes give no item.
// Reset: synchronous, active low; clears the queue, handshakes and both
//   geometry registers (one page per unit, one unit per I/O unit).
// ----------------------------------------------------------------------------
module block_request_splitter_top (
  input  logic      clk,
  input  logic      rst_n,
  brs_in_if.sink    in_ch,
  brs_out_if.source out_ch,
  brs_cfg_if.sink   cfg_ch
);
  import brs_pkg::*;

  // Geometry registers, as written by the host.
  logic [CFG_DATA_W-1:0] pages_log_r;
  logic [CFG_DATA_W-1:0] units_log_r;

  // Effective geometry: a piece never spans more than 32 page slots, so the
  // page shift is capped first and the unit shift takes what is left.
  geom_t      geom;
  logic [2:0] lm_lim;

  logic  q_push, q_full, q_pop, q_valid;
  desc_t q_in, q_out;

  // Config writes are always taken; unknown indexes are ignored.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pages_log_r <= '0;
      units_log_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_IDX_PAGES: pages_log_r <= cfg_ch.data;
        CFG_IDX_UNITS: units_log_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.lp = (pages_log_r > 3'(MAX_SLOTS_LOG2)) ? 3'(MAX_SLOTS_LOG2) : pages_log_r;
    lm_lim  = 3'(MAX_SLOTS_LOG2) - geom.lp;
    geom.lm = (units_log_r > lm_lim) ? lm_lim : units_log_r;
  end

  // Front: takes a request, classifies it and sizes the piece run.
  brs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .geom   (geom),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // Queue decouples intake from piece generation.
  brs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out)
  );

  // Back: emits pieces one per cycle unless stalled, via the output register.
  brs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
